// ----- rtl/core/dtf_pkg.sv -----
package dtf_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SUM_W   = 34;
  localparam int MAG_W   = 35;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int TERM_W  = 68;
  localparam int KMAG_W  = 67;
  localparam int ACC_W   = 138;
  localparam int IDX_W   = 16;
  localparam int POS_W   = 16;
  localparam int LIMIT_W = 31;

  localparam logic [0:0] REG_AREA_LIMIT     = 1'b0;
  localparam logic [0:0] REG_DISTANCE_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] AREA_LIMIT_RESET     = 31'd10;
  localparam logic [LIMIT_W-1:0] DISTANCE_LIMIT_RESET = 31'd10;

  typedef enum logic [2:0] {
    M_NONE,
    M_PQ,
    M_RS,
    M_LL,
    M_HL,
    M_HH,
    M_AL,
    M_DL
  } mul_sel_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_TERM,
    A_KFORM,
    A_KABS,
    A_ACC0,
    A_ACC35,
    A_ACC68,
    A_AREA_CMP,
    A_DLIM,
    A_LOAD_D,
    A_DCMP
  } act_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     mul_dist;
    act_t     act;
    logic [1:0] axis;
    logic     commit;
  } dtf_cmd_t;

  typedef struct packed {
    logic out_free;
  } dtf_status_t;

endpackage

// ----- rtl/core/dtf_ram.sv -----
module dtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dtf_datapath.sv -----
module dtf_datapath #(
  parameter int WINDOW = 10,
  parameter int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dtf_pkg::dtf_cmd_t           cmd,
  output dtf_pkg::dtf_status_t        status,
  input  logic [ADDR_W-1:0]           raddr,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [30:0]                 cfg_data,
  input  logic [15:0]                 corner_a_index,
  input  logic [15:0]                 corner_b_index,
  input  logic [15:0]                 corner_c_index,
  input  logic signed [31:0]          corner_a_x,
  input  logic signed [31:0]          corner_a_y,
  input  logic signed [31:0]          corner_a_z,
  input  logic signed [31:0]          corner_b_x,
  input  logic signed [31:0]          corner_b_y,
  input  logic signed [31:0]          corner_b_z,
  input  logic signed [31:0]          corner_c_x,
  input  logic signed [31:0]          corner_c_y,
  input  logic signed [31:0]          corner_c_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 kept_a_index,
  output logic [15:0]                 kept_b_index,
  output logic [15:0]                 kept_c_index,
  output logic [15:0]                 kept_position
);
  import dtf_pkg::*;

  logic [31:0]             al2;
  logic [32:0]             dl3;
  logic [IDX_W-1:0]        idx_a, idx_b, idx_c;
  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [SUM_W-1:0]  s [3];
  logic [PROD_W-1:0]       prod;
  logic                    psign;
  logic signed [TERM_W-1:0] t;
  logic signed [TERM_W-1:0] k;
  logic [KMAG_W-1:0]       kmag;
  logic [MAG_W-1:0]        dmag [3];
  logic [ACC_W-1:0]        acc;
  logic [65:0]             dlim;
  logic                    drop;
  logic [POS_W-1:0]        kept_total;

  logic [MAG_W-1:0]        a_op, b_op;
  logic                    sign_next;
  logic [1:0]              i1, i2;
  logic signed [TERM_W-1:0] sprod;
  logic [3*SUM_W-1:0]      rd_word;
  logic [3*SUM_W-1:0]      wr_word;
  logic [ACC_W-1:0]        add_val;
  logic signed [MAG_W-1:0] ddiff [3];
  logic [MAG_W-1:0]        dabs [3];
  logic signed [DIFF_W-1:0] op_p, op_q;

  dtf_ram #(.WIDTH(3 * SUM_W), .DEPTH(WINDOW), .ADDR_W(ADDR_W)) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (waddr),
    .wdata (wr_word),
    .raddr (raddr),
    .rdata (rd_word)
  );

  assign wr_word = {s[2], s[1], s[0]};
  assign status.out_free = !out_valid || out_ready;

  // Cross product component c is u[c+1]*v[c+2] - u[c+2]*v[c+1], indices mod 3.
  always_comb begin
    case (cmd.axis)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  always_comb begin
    op_p = '0;
    op_q = '0;
    a_op = '0;
    b_op = '0;
    sign_next = 1'b0;
    if (cmd.mul_dist) begin
      a_op = dmag[cmd.axis];
      b_op = dmag[cmd.axis];
    end else begin
      case (cmd.mul_sel)
        M_PQ, M_RS: begin
          op_p = (cmd.mul_sel == M_PQ) ? u[i1] : u[i2];
          op_q = (cmd.mul_sel == M_PQ) ? v[i2] : v[i1];
          a_op = MAG_W'(op_p[DIFF_W-1] ? DIFF_W'(-op_p) : DIFF_W'(op_p));
          b_op = MAG_W'(op_q[DIFF_W-1] ? DIFF_W'(-op_q) : DIFF_W'(op_q));
          sign_next = op_p[DIFF_W-1] ^ op_q[DIFF_W-1];
        end
        M_LL: begin
          a_op = {1'b0, kmag[33:0]};
          b_op = {1'b0, kmag[33:0]};
        end
        M_HL: begin
          a_op = {2'b00, kmag[KMAG_W-1:34]};
          b_op = {1'b0, kmag[33:0]};
        end
        M_HH: begin
          a_op = {2'b00, kmag[KMAG_W-1:34]};
          b_op = {2'b00, kmag[KMAG_W-1:34]};
        end
        M_AL: begin
          a_op = MAG_W'(al2);
          b_op = MAG_W'(al2);
        end
        M_DL: begin
          a_op = MAG_W'(dl3);
          b_op = MAG_W'(dl3);
        end
        default: ;
      endcase
    end
  end

  assign sprod = psign ? -$signed({1'b0, prod[TERM_W-2:0]})
                       : $signed({1'b0, prod[TERM_W-2:0]});

  always_comb begin
    case (cmd.act)
      A_ACC35: add_val = ACC_W'({prod, 35'd0});
      A_ACC68: add_val = ACC_W'({prod, 68'd0});
      default: add_val = ACC_W'(prod);
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_dist
    assign ddiff[g] = $signed({s[g][SUM_W-1], s[g]})
                    - $signed({rd_word[g*SUM_W+SUM_W-1], rd_word[g*SUM_W +: SUM_W]});
    assign dabs[g]  = ddiff[g][MAG_W-1] ? MAG_W'(-ddiff[g]) : MAG_W'(ddiff[g]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      al2        <= {AREA_LIMIT_RESET, 1'b0};
      dl3        <= 33'(DISTANCE_LIMIT_RESET) + 33'({DISTANCE_LIMIT_RESET, 1'b0});
      out_valid  <= 1'b0;
      kept_total <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_AREA_LIMIT) begin
          al2 <= {cfg_data, 1'b0};
        end else begin
          dl3 <= 33'(cfg_data) + 33'({cfg_data, 1'b0});
        end
      end
      if (cmd.commit && !drop) begin
        out_valid <= 1'b1;
        if (kept_total != '1) begin
          kept_total <= kept_total + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= a_op * b_op;
    psign <= sign_next;
    if (cmd.load) begin
      idx_a <= corner_a_index;
      idx_b <= corner_b_index;
      idx_c <= corner_c_index;
      u[0]  <= DIFF_W'(corner_b_x) - DIFF_W'(corner_a_x);
      u[1]  <= DIFF_W'(corner_b_y) - DIFF_W'(corner_a_y);
      u[2]  <= DIFF_W'(corner_b_z) - DIFF_W'(corner_a_z);
      v[0]  <= DIFF_W'(corner_c_x) - DIFF_W'(corner_a_x);
      v[1]  <= DIFF_W'(corner_c_y) - DIFF_W'(corner_a_y);
      v[2]  <= DIFF_W'(corner_c_z) - DIFF_W'(corner_a_z);
      s[0]  <= SUM_W'(corner_a_x) + SUM_W'(corner_b_x) + SUM_W'(corner_c_x);
      s[1]  <= SUM_W'(corner_a_y) + SUM_W'(corner_b_y) + SUM_W'(corner_c_y);
      s[2]  <= SUM_W'(corner_a_z) + SUM_W'(corner_b_z) + SUM_W'(corner_c_z);
      acc   <= '0;
      drop  <= 1'b0;
    end
    case (cmd.act)
      A_TERM:  t <= sprod;
      A_KFORM: k <= t - sprod;
      A_KABS:  kmag <= k[TERM_W-1] ? KMAG_W'(-k) : KMAG_W'(k);
      A_ACC0, A_ACC35, A_ACC68: acc <= acc + add_val;
      // The area limit product is squared (2*limit) and still needs the 2^40 scale.
      A_AREA_CMP: begin
        drop <= acc < ACC_W'({prod[63:0], 40'd0});
        acc  <= '0;
      end
      A_DLIM: dlim <= prod[65:0];
      A_LOAD_D: begin
        dmag[0] <= dabs[0];
        dmag[1] <= dabs[1];
        dmag[2] <= dabs[2];
        acc     <= '0;
      end
      A_DCMP: drop <= drop | (acc < ACC_W'(dlim));
      default: ;
    endcase
    if (cmd.commit && !drop) begin
      kept_a_index  <= idx_a;
      kept_b_index  <= idx_b;
      kept_c_index  <= idx_c;
      kept_position <= kept_total;
    end
  end

endmodule

// ----- rtl/core/dtf_controller.sv -----
module dtf_controller #(
  parameter int WINDOW = 10,
  parameter int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  parameter int CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output dtf_pkg::dtf_cmd_t      cmd,
  input  dtf_pkg::dtf_status_t   status,
  output logic [ADDR_W-1:0]      raddr,
  output logic [ADDR_W-1:0]      waddr
);
  import dtf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AREA,
    S_DIST,
    S_FINISH
  } state_t;

  state_t            state;
  logic [3:0]        step;
  logic [1:0]        comp;
  logic [ADDR_W-1:0] entry;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              last_entry;

  assign in_ready   = (state == S_IDLE);
  assign raddr      = entry;
  assign waddr      = head;
  assign last_entry = (CNT_W'(entry) + 1'b1) == count;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = M_NONE;
    cmd.act      = A_NONE;
    cmd.load     = in_valid && in_ready;
    unique case (state)
      S_IDLE: ;
      S_AREA: begin
        cmd.axis = comp;
        unique case (step)
          4'd0: cmd.mul_sel = M_PQ;
          4'd1: begin cmd.mul_sel = M_RS; cmd.act = A_TERM; end
          4'd2: cmd.act = A_KFORM;
          4'd3: cmd.act = A_KABS;
          4'd4: cmd.mul_sel = M_LL;
          4'd5: begin cmd.mul_sel = M_HL; cmd.act = A_ACC0; end
          4'd6: begin cmd.mul_sel = M_HH; cmd.act = A_ACC35; end
          4'd7: cmd.act = A_ACC68;
          4'd8: cmd.mul_sel = M_AL;
          4'd9: begin cmd.mul_sel = M_DL; cmd.act = A_AREA_CMP; end
          4'd10: cmd.act = A_DLIM;
          default: ;
        endcase
      end
      S_DIST: begin
        unique case (step)
          4'd1: cmd.act = A_LOAD_D;
          4'd2: begin cmd.mul_dist = 1'b1; cmd.axis = 2'd0; end
          4'd3: begin cmd.mul_dist = 1'b1; cmd.axis = 2'd1; cmd.act = A_ACC0; end
          4'd4: begin cmd.mul_dist = 1'b1; cmd.axis = 2'd2; cmd.act = A_ACC0; end
          4'd5: cmd.act = A_ACC0;
          4'd6: cmd.act = A_DCMP;
          default: ;
        endcase
      end
      S_FINISH: cmd.commit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      comp  <= '0;
      entry <= '0;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_AREA;
            step  <= '0;
            comp  <= '0;
          end
        end
        S_AREA: begin
          if (step == 4'd7 && comp != 2'd2) begin
            comp <= comp + 1'b1;
            step <= '0;
          end else if (step == 4'd10) begin
            step  <= '0;
            entry <= '0;
            state <= (count == '0) ? S_FINISH : S_DIST;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIST: begin
          if (step == 4'd6) begin
            step <= '0;
            if (last_entry) begin
              state <= S_FINISH;
            end else begin
              entry <= entry + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FINISH: begin
          if (status.out_free) begin
            state <= S_IDLE;
            head  <= (head == ADDR_W'(WINDOW - 1)) ? '0 : head + 1'b1;
            if (count != CNT_W'(WINDOW)) begin
              count <= count + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/degenerate_triangle_filter_core.sv -----
// Degenerate triangle filter.
// Input channel (in_valid/in_ready) takes one triangle word: three vertex
// indices and nine signed Q12.20 coordinates. Output channel
// (out_valid/out_ready) gives one word for each kept triangle: its indices
// and its position in the compacted list, saturating at 65535.
// Configuration writes (cfg_write, cfg_index, cfg_data) set the area and
// distance limits and take effect at once; write them only while idle.
// One item is in flight at a time. The result word is presented in the same
// cycle as the input becomes ready again. The work runs on the single shared
// 35x35 multiplier: 27 steps for the squared cross product and limits, then 7
// steps per stored earlier centroid (at most WINDOW), each of which reads one
// entry from the centroid memory, and one final step that commits the item.
// A result waits in the output register while the next item is taken in;
// if the receiver still stalls when the following result is ready, the
// block holds in its final step until the register frees.
// Reset clears the window, the kept count and the output; both limits
// return to 10.
module degenerate_triangle_filter_core #(
  parameter int WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        corner_a_index,
  input  logic [15:0]        corner_b_index,
  input  logic [15:0]        corner_c_index,
  input  logic signed [31:0] corner_a_x,
  input  logic signed [31:0] corner_a_y,
  input  logic signed [31:0] corner_a_z,
  input  logic signed [31:0] corner_b_x,
  input  logic signed [31:0] corner_b_y,
  input  logic signed [31:0] corner_b_z,
  input  logic signed [31:0] corner_c_x,
  input  logic signed [31:0] corner_c_y,
  input  logic signed [31:0] corner_c_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        kept_a_index,
  output logic [15:0]        kept_b_index,
  output logic [15:0]        kept_c_index,
  output logic [15:0]        kept_position
);
  import dtf_pkg::*;

  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  dtf_cmd_t          cmd;
  dtf_status_t       status;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;

  dtf_controller #(.WINDOW(WINDOW), .ADDR_W(ADDR_W)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status),
    .raddr    (raddr),
    .waddr    (waddr)
  );

  dtf_datapath #(.WINDOW(WINDOW), .ADDR_W(ADDR_W)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .raddr          (raddr),
    .waddr          (waddr),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .corner_a_index (corner_a_index),
    .corner_b_index (corner_b_index),
    .corner_c_index (corner_c_index),
    .corner_a_x     (corner_a_x),
    .corner_a_y     (corner_a_y),
    .corner_a_z     (corner_a_z),
    .corner_b_x     (corner_b_x),
    .corner_b_y     (corner_b_y),
    .corner_b_z     (corner_b_z),
    .corner_c_x     (corner_c_x),
    .corner_c_y     (corner_c_y),
    .corner_c_z     (corner_c_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kept_a_index   (kept_a_index),
    .kept_b_index   (kept_b_index),
    .kept_c_index   (kept_c_index),
    .kept_position  (kept_position)
  );

endmodule

// ----- rtl/core/dtf_checker.sv -----
module dtf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] kept_a_index,
  input logic [15:0] kept_position
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kept_a_index)
                                && $stable(kept_position))
    else $error("result word changed while stalled");

  // Only one triangle is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A new result only appears as a triangle finishes.
  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a triangle in work");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind degenerate_triangle_filter_core dtf_checker u_dtf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kept_a_index  (kept_a_index),
  .kept_position (kept_position)
);

// ----- bench/degenerate_triangle_filter_core_tb.sv -----
`timescale 1ns / 1ps

module degenerate_triangle_filter_core_tb;
  import dtf_pkg::*;

  typedef logic signed [143:0] big_t;

  typedef struct {
    logic [15:0]        ia, ib, ic;
    logic signed [31:0] c [9];
  } triangle_t;

  typedef struct {
    logic [15:0] ia, ib, ic, pos;
  } kept_word_t;

  class kept_scoreboard;
    logic [30:0] area_lim, dist_lim;
    big_t        sum_x [10], sum_y [10], sum_z [10];
    int          head, filled, kept_count, errors;
    kept_word_t  awaited [$];

    function new();
      area_lim = AREA_LIMIT_RESET;
      dist_lim = DISTANCE_LIMIT_RESET;
      head = 0;
      filled = 0;
      kept_count = 0;
      errors = 0;
    endfunction

    function void set_limit(logic [0:0] idx, logic [30:0] v);
      if (idx == REG_AREA_LIMIT) area_lim = v;
      else dist_lim = v;
    endfunction

    // Works out whether the triangle survives and queues its word if so.
    function void note_triangle(triangle_t t);
      big_t ax, ay, az, bx, by, bz, cx, cy, cz;
      big_t ux, uy, uz, vx, vy, vz, kx, ky, kz, norm, lim, sx, sy, sz, dx, dy, dz;
      bit drop;
      kept_word_t w;
      ax = t.c[0]; ay = t.c[1]; az = t.c[2];
      bx = t.c[3]; by = t.c[4]; bz = t.c[5];
      cx = t.c[6]; cy = t.c[7]; cz = t.c[8];
      ux = bx - ax; uy = by - ay; uz = bz - az;
      vx = cx - ax; vy = cy - ay; vz = cz - az;
      kx = uy * vz - uz * vy;
      ky = uz * vx - ux * vz;
      kz = ux * vy - uy * vx;
      norm = kx * kx + ky * ky + kz * kz;
      lim = {113'd0, area_lim};
      lim = lim * 2;
      lim = (lim * lim) <<< 40;
      drop = norm < lim;
      sx = ax + bx + cx; sy = ay + by + cy; sz = az + bz + cz;
      lim = {113'd0, dist_lim};
      lim = lim * 3;
      lim = lim * lim;
      for (int i = 0; i < filled; i++) begin
        dx = sx - sum_x[i]; dy = sy - sum_y[i]; dz = sz - sum_z[i];
        if (dx * dx + dy * dy + dz * dz < lim) drop = 1;
      end
      sum_x[head] = sx; sum_y[head] = sy; sum_z[head] = sz;
      head = (head == 9) ? 0 : head + 1;
      if (filled < 10) filled++;
      if (!drop) begin
        w.ia = t.ia; w.ib = t.ib; w.ic = t.ic;
        w.pos = kept_count[15:0];
        if (kept_count < 65535) kept_count++;
        awaited.push_back(w);
      end
    endfunction

    function void check_kept(kept_word_t got);
      kept_word_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, actual %h %h %h pos %0d", $time,
                 got.ia, got.ib, got.ic, got.pos);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.ia !== exp.ia) begin
        $display("%0t: kept_a_index expected %h actual %h", $time, exp.ia, got.ia);
        errors++;
      end
      if (got.ib !== exp.ib) begin
        $display("%0t: kept_b_index expected %h actual %h", $time, exp.ib, got.ib);
        errors++;
      end
      if (got.ic !== exp.ic) begin
        $display("%0t: kept_c_index expected %h actual %h", $time, exp.ic, got.ic);
        errors++;
      end
      if (got.pos !== exp.pos) begin
        $display("%0t: kept_position expected %0d actual %0d", $time, exp.pos, got.pos);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [0:0]  cfg_index = REG_AREA_LIMIT;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] kept_a_index, kept_b_index, kept_c_index, kept_position;
  triangle_t   cur;
  bit          quiet = 0;

  kept_scoreboard sb = new();
  triangle_t      history [$];

  always #1 clk = ~clk;

  degenerate_triangle_filter_core uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .corner_a_index(cur.ia), .corner_b_index(cur.ib), .corner_c_index(cur.ic),
    .corner_a_x(cur.c[0]), .corner_a_y(cur.c[1]), .corner_a_z(cur.c[2]),
    .corner_b_x(cur.c[3]), .corner_b_y(cur.c[4]), .corner_b_z(cur.c[5]),
    .corner_c_x(cur.c[6]), .corner_c_y(cur.c[7]), .corner_c_z(cur.c[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_a_index(kept_a_index), .kept_b_index(kept_b_index),
    .kept_c_index(kept_c_index), .kept_position(kept_position)
  );

  task automatic send_triangle(triangle_t t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cur <= t;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(t);
    history.push_back(t);
    if (history.size() > 12) void'(history.pop_front());
  endtask

  task automatic write_limit(logic [0:0] idx, logic [30:0] v);
    in_valid <= 0;
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_limit(idx, v);
  endtask

  // Waits until every kept word is out, then lets the last dropped item drain.
  task automatic drain();
    in_valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic triangle_t right_triangle(int ox, int oy, int oz, int b, int c);
    triangle_t t;
    t.ia = 16'($urandom); t.ib = 16'($urandom); t.ic = 16'($urandom);
    t.c[0] = ox;     t.c[1] = oy;     t.c[2] = oz;
    t.c[3] = ox + b; t.c[4] = oy;     t.c[5] = oz;
    t.c[6] = ox;     t.c[7] = oy + c; t.c[8] = oz;
    return t;
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int        kind, base, k;
    kind = $urandom_range(0, 99);
    t.ia = 16'($urandom); t.ib = 16'($urandom); t.ic = 16'($urandom);
    for (int i = 0; i < 9; i++) t.c[i] = $urandom;
    if (kind >= 50 && kind < 65) begin
      for (int i = 0; i < 9; i++) t.c[i] = $signed($urandom_range(0, 8191)) - 4096;
    end else if (kind >= 65 && kind < 80 && history.size() > 0) begin
      // Swap two corners of a recent triangle and move one coordinate by at most 20, so its centroid nearly repeats.
      t = history[$urandom_range(0, history.size() - 1)];
      t.ia = 16'($urandom);
      for (int i = 0; i < 3; i++) begin
        k = t.c[i]; t.c[i] = t.c[i + 3]; t.c[i + 3] = k;
      end
      k = $urandom_range(0, 8);
      t.c[k] = t.c[k] + $signed($urandom_range(0, 40)) - 20;
    end else if (kind >= 80 && kind < 95) begin
      k = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        if (k == 0) t.c[6 + i] = t.c[i];
        else if (k == 1) t.c[6 + i] = t.c[3 + i];
        else t.c[6 + i] = 2 * t.c[3 + i] - t.c[i];
      end
    end else if (kind >= 95) begin
      base = $urandom;
      t = right_triangle(base, base >>> 3, -base,
                         $urandom_range(1, 1 << 23), $urandom_range(1, 1 << 23));
    end
    return t;
  endfunction

  initial begin
    kept_word_t w;
    int         n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      w.ia = kept_a_index; w.ib = kept_b_index; w.ic = kept_c_index;
      w.pos = kept_position;
      sb.check_kept(w);
    end
  end

  initial begin
    logic [30:0] area_set [7], dist_set [7];
    triangle_t   t;
    cur.ia = 0; cur.ib = 0; cur.ic = 0;
    for (int i = 0; i < 9; i++) cur.c[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset limits first: area exactly at the limit, one below, corner extremes.
    send_triangle(right_triangle(0, 0, 0, 20 << 20, 1));
    send_triangle(right_triangle(1 << 24, 0, 0, (20 << 20) - 1, 1));
    send_triangle(right_triangle(0, 0, 0, 20 << 20, 1));
    send_triangle(right_triangle(10, 0, 0, 20 << 20, 1));
    send_triangle(right_triangle(1 << 26, 0, 0, 1 << 24, 1 << 24));
    send_triangle(right_triangle((1 << 26) + 9, 1, 0, 1 << 24, 1 << 24));
    send_triangle(right_triangle(0, 0, 0, 0, 0));
    t.ia = 16'hFFFF; t.ib = 16'hFFFF; t.ic = 16'hFFFF;
    for (int i = 0; i < 9; i++) t.c[i] = (i % 4 == 0) ? 32'h7FFFFFFF : 32'h80000000;
    send_triangle(t);
    t.ia = 0; t.ib = 16'hFFFF; t.ic = 0;
    for (int i = 0; i < 9; i++) t.c[i] = (i % 3 == 1) ? 32'h7FFFFFFF : 32'h80000000;
    send_triangle(t);
    send_triangle(t);
    for (int i = 0; i < 12; i++)
      send_triangle(right_triangle(i << 27, -(i << 26), i << 25, 1 << 22, 1 << 22));
    drain();

    area_set = '{31'd0, 31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 31'd10, 31'd300, 31'd0};
    dist_set = '{31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0, 31'd10, 31'd5000, 31'd0};
    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        area_set[p] = 31'($urandom_range(0, 1 << 20));
        dist_set[p] = 31'($urandom_range(0, 1 << 16));
      end
      write_limit(REG_AREA_LIMIT, area_set[p]);
      write_limit(REG_DISTANCE_LIMIT, dist_set[p]);
      for (int i = 0; i < 218; i++) begin
        if ($urandom_range(0, 39) == 0) quiet = ~quiet;
        send_triangle(random_triangle());
      end
      quiet = 0;
      drain();
    end

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
